/* design/salsa20_pkg.sv */
// ----------------------------------------------------------------------------
// salsa20_pkg
// Shared types and constants for the Salsa20 byte stream cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package salsa20_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int STEP_CNT_W = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_KEY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DBL_RNDS  = 3'd6;

  localparam logic       WIDE_KEY_RST = 1'b1;
  localparam logic [3:0] DBL_RNDS_RST = 4'd10;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;
  // "expand 16-byte k"
  localparam logic [31:0] TAU0   = 32'h6170_7865;
  localparam logic [31:0] TAU1   = 32'h3120_646e;
  localparam logic [31:0] TAU2   = 32'h7962_2d36;
  localparam logic [31:0] TAU3   = 32'h6b20_6574;

  localparam logic [4:0] ROT_A = 5'd7;
  localparam logic [4:0] ROT_B = 5'd9;
  localparam logic [4:0] ROT_C = 5'd13;
  localparam logic [4:0] ROT_D = 5'd18;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load;       // take item, load state matrix
    logic       rnd;        // apply one quarter-round step
    logic [1:0] step;
    logic       finish;     // feed-forward add, bump counter
    logic       emit_in;    // result from the item on the input
    logic       emit_held;  // result from the held item
    logic       restart;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                  pos_zero;
    logic                  out_free;
    logic [STEP_CNT_W-1:0] total_steps;
  } dp_status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {v, v} << n;
    return dbl[63:32];
  endfunction

endpackage

`default_nettype wire

/* design/salsa20_stream_if.sv */
// ----------------------------------------------------------------------------
// salsa20 stream channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface salsa20_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_in;
  logic       last;

  modport source (output valid, output kind, output data_in, output last, input ready);
  modport sink   (input valid, input kind, input data_in, input last, output ready);
endinterface

interface salsa20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_out;

  modport source (output valid, output data_out, output last_out, input ready);
  modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

`default_nettype wire

/* design/salsa20_ctrl.sv */
// ----------------------------------------------------------------------------
// salsa20_ctrl
// Sequencer: accepts items, runs the quarter-round steps of a block and
// orders the result.
// ----------------------------------------------------------------------------
`default_nettype none

module salsa20_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_kind,
  output logic                        in_ready,
  input  wire salsa20_pkg::dp_status_t status,
  output salsa20_pkg::ctrl_cmd_t      cmd
);

  salsa20_pkg::state_t state, state_next;
  logic [salsa20_pkg::STEP_CNT_W-1:0] step_cnt, step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= salsa20_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      salsa20_pkg::ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          if (in_kind) begin
            cmd.restart = 1'b1;
          end else if (status.pos_zero) begin
            // new keystream block needed before this byte
            cmd.load      = 1'b1;
            step_cnt_next = '0;
            state_next    = salsa20_pkg::ST_ROUND;
          end else begin
            cmd.emit_in = 1'b1;
          end
        end
      end
      salsa20_pkg::ST_ROUND: begin
        if (step_cnt == status.total_steps) begin
          cmd.finish = 1'b1;
          state_next = salsa20_pkg::ST_EMIT;
        end else begin
          cmd.rnd       = 1'b1;
          cmd.step      = step_cnt[1:0];
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      salsa20_pkg::ST_EMIT: begin
        cmd.emit_held = 1'b1;
        state_next    = salsa20_pkg::ST_IDLE;
      end
      default: begin
        state_next = salsa20_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/salsa20_dp.sv */
// ----------------------------------------------------------------------------
// salsa20_dp
// Datapath: configuration registers, state matrix with quarter-round step
// unit, keystream buffer, block counter, byte position and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module salsa20_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [salsa20_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [salsa20_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire salsa20_pkg::ctrl_cmd_t               cmd,
  output salsa20_pkg::dp_status_t                   status,
  input  wire logic [7:0]                           in_data,
  input  wire logic                                 in_last,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [7:0]                                out_data,
  output logic                                      out_last
);

  logic [63:0] key_lo, key_mid, key_upper, key_top, nonce;
  logic        wide_key;
  logic [3:0]  double_rounds;

  logic [63:0] block_counter;
  logic [5:0]  byte_pos;
  logic [31:0] x [16];
  logic [31:0] ks [16];
  logic [31:0] init_m [16];
  logic [31:0] x_step [16];
  logic [31:0] x_next [16];
  logic [7:0]  hold_data;
  logic        hold_last;
  logic [31:0] ks_word;
  logic [31:0] ks_shift;
  logic [7:0]  ks_byte;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      key_lo        <= '0;
      key_mid       <= '0;
      key_upper     <= '0;
      key_top       <= '0;
      nonce         <= '0;
      wide_key      <= salsa20_pkg::WIDE_KEY_RST;
      double_rounds <= salsa20_pkg::DBL_RNDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        salsa20_pkg::REG_KEY_LO:    key_lo        <= cfg_data;
        salsa20_pkg::REG_KEY_MID:   key_mid       <= cfg_data;
        salsa20_pkg::REG_KEY_UPPER: key_upper     <= cfg_data;
        salsa20_pkg::REG_KEY_TOP:   key_top       <= cfg_data;
        salsa20_pkg::REG_NONCE:     nonce         <= cfg_data;
        salsa20_pkg::REG_WIDE_KEY:  wide_key      <= cfg_data[0];
        salsa20_pkg::REG_DBL_RNDS:  double_rounds <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input matrix, also used for the feed-forward add
  always_comb begin
    logic [63:0] k2, k3;
    k2 = wide_key ? key_upper : key_lo;
    k3 = wide_key ? key_top   : key_mid;
    init_m[0]  = wide_key ? salsa20_pkg::SIGMA0 : salsa20_pkg::TAU0;
    init_m[1]  = key_lo[31:0];
    init_m[2]  = key_lo[63:32];
    init_m[3]  = key_mid[31:0];
    init_m[4]  = key_mid[63:32];
    init_m[5]  = wide_key ? salsa20_pkg::SIGMA1 : salsa20_pkg::TAU1;
    init_m[6]  = nonce[31:0];
    init_m[7]  = nonce[63:32];
    init_m[8]  = block_counter[31:0];
    init_m[9]  = block_counter[63:32];
    init_m[10] = wide_key ? salsa20_pkg::SIGMA2 : salsa20_pkg::TAU2;
    init_m[11] = k2[31:0];
    init_m[12] = k2[63:32];
    init_m[13] = k3[31:0];
    init_m[14] = k3[63:32];
    init_m[15] = wide_key ? salsa20_pkg::SIGMA3 : salsa20_pkg::TAU3;
  end

  // one quarter-round step on all four columns; a row round is a column
  // round on the transposed matrix, so the matrix is transposed after step 3
  always_comb begin
    logic [3:0] ia, ib, ic, id;
    x_step = x;
    for (int j = 0; j < 4; j++) begin
      ia = 4'((5 * j) & 15);
      ib = 4'((5 * j + 4) & 15);
      ic = 4'((5 * j + 8) & 15);
      id = 4'((5 * j + 12) & 15);
      case (cmd.step)
        2'd0: x_step[ib] = x[ib] ^ salsa20_pkg::rotl32(x[ia] + x[id], salsa20_pkg::ROT_A);
        2'd1: x_step[ic] = x[ic] ^ salsa20_pkg::rotl32(x[ib] + x[ia], salsa20_pkg::ROT_B);
        2'd2: x_step[id] = x[id] ^ salsa20_pkg::rotl32(x[ic] + x[ib], salsa20_pkg::ROT_C);
        default: x_step[ia] = x[ia] ^ salsa20_pkg::rotl32(x[id] + x[ic], salsa20_pkg::ROT_D);
      endcase
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        x_next[r * 4 + c] = (cmd.step == 2'd3) ? x_step[c * 4 + r] : x_step[r * 4 + c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x         <= init_m;
      hold_data <= in_data;
      hold_last <= in_last;
    end else if (cmd.rnd) begin
      x <= x_next;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++) begin
        ks[i] <= x[i] + init_m[i];
      end
    end
  end

  assign ks_word  = ks[byte_pos[5:2]];
  assign ks_shift = ks_word >> {byte_pos[1:0], 3'b000};
  assign ks_byte  = ks_shift[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      byte_pos      <= '0;
    end else if (cmd.restart) begin
      block_counter <= '0;
      byte_pos      <= '0;
    end else begin
      if (cmd.finish) begin
        block_counter <= block_counter + 64'd1;
      end
      if (cmd.emit_in) begin
        byte_pos <= in_last ? 6'd0 : byte_pos + 6'd1;
      end else if (cmd.emit_held) begin
        byte_pos <= hold_last ? 6'd0 : byte_pos + 6'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_in || cmd.emit_held) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_in) begin
      out_data <= in_data ^ ks_byte;
      out_last <= in_last;
    end else if (cmd.emit_held) begin
      out_data <= hold_data ^ ks_byte;
      out_last <= hold_last;
    end
  end

  assign status.pos_zero    = (byte_pos == 6'd0);
  assign status.out_free    = !out_valid || out_ready;
  assign status.total_steps = {double_rounds, 3'b000};

endmodule

`default_nettype wire

/* design/salsa20_stream_cipher_core.sv */
// ----------------------------------------------------------------------------
// salsa20_stream_cipher_core
// Salsa20 byte stream cipher with 64-bit nonce and 64-bit block counter.
// ----------------------------------------------------------------------------
// One item is one byte (or a restart). The result of a byte inside a keystream
// block sits in the output register the cycle after the byte is taken. A
// byte at position zero first builds a new 64-byte block: the quarter-round
// unit applies one of the four quarter-round steps to all four columns per
// cycle, through double_rounds double rounds (ten at reset), then the
// feed-forward add forms the keystream block and the result is formed from
// it. A restart gives no result. Input is held off while a result waits in
// the output register and is not taken in the same cycle.
`default_nettype none

module salsa20_stream_cipher_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [salsa20_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [salsa20_pkg::CFG_DATA_W-1:0] cfg_data,
  salsa20_in_if.sink                              in_ch,
  salsa20_out_if.source                           out_ch
);

  salsa20_pkg::ctrl_cmd_t cmd;
  salsa20_pkg::dp_status_t status;

  salsa20_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  salsa20_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_ch.data_in),
    .in_last   (in_ch.last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data_out),
    .out_last  (out_ch.last_out)
  );

endmodule

`default_nettype wire

/* design/salsa20_chk.sv */
// ----------------------------------------------------------------------------
// salsa20_chk
// Port-level checks for the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module salsa20_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_kind,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_data,
  input wire logic       out_last
);

  // a restart item never yields a result
  a_restart_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_kind) |=> !out_valid)
    else $error("result after restart item");

  // a data item either shows its result next or keeps the input held off
  a_data_progress: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_kind) |=> (out_valid || !in_ready))
    else $error("data item neither answered nor blocking input");

  // no item taken while a result is stuck in the output register
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input ready while result stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind salsa20_stream_cipher_core salsa20_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data_out),
  .out_last  (out_ch.last_out)
);

`default_nettype wire
